FILE: hw/rtl/mnm_pkg.sv
package mnm_pkg;

  // needle slots held in registers and slots searched
  localparam int unsigned REG_SLOTS      = 4;
  localparam int unsigned NEEDLE_SLOTS   = 4;
  localparam int unsigned LIVE_SLOTS     = (NEEDLE_SLOTS < REG_SLOTS) ? NEEDLE_SLOTS : REG_SLOTS;
  localparam int unsigned MAX_NEEDLE_LEN = 8;
  localparam int unsigned POS_W          = (MAX_NEEDLE_LEN > 1) ? $clog2(MAX_NEEDLE_LEN) : 1;

  localparam int unsigned NEEDLE_W = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned LENS_W   = 16;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned APB_AW   = 6;
  localparam int unsigned APB_DW   = 64;

  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5a;
  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] LOWER_Z  = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [2:0] {
    REG_NEEDLE_A = 3'd0,
    REG_NEEDLE_B = 3'd1,
    REG_NEEDLE_C = 3'd2,
    REG_NEEDLE_D = 3'd3,
    REG_LENGTHS  = 3'd4,
    REG_COUNT    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [REG_SLOTS-1:0][NEEDLE_W-1:0] needle;
    logic [REG_SLOTS-1:0][LEN_W-1:0]    len;
    logic [COUNT_W-1:0]                 count;
  } cfg_t;

  // one window position: byte and whether it holds stream data
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
  } win_t;

  // map upper-case letters onto lower case
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_GAP;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/mnm_cfg.sv
module mnm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mnm_pkg::APB_AW-1:0]  paddr,
  input  logic [mnm_pkg::APB_DW-1:0]  pwdata,
  output logic [mnm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output mnm_pkg::cfg_t               cfg_o
);
  import mnm_pkg::*;

  logic [REG_SLOTS-1:0][NEEDLE_W-1:0] needle_q, needle_d;
  logic [LENS_W-1:0]                  lens_q, lens_d;
  logic [COUNT_W-1:0]                 count_q, count_d;
  logic [2:0]                         idx;
  logic                               wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:3];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    needle_d = needle_q;
    lens_d   = lens_q;
    count_d  = count_q;
    if (wr_en) begin
      unique case (idx)
        REG_NEEDLE_A: needle_d[0] = pwdata;
        REG_NEEDLE_B: needle_d[1] = pwdata;
        REG_NEEDLE_C: needle_d[2] = pwdata;
        REG_NEEDLE_D: needle_d[3] = pwdata;
        REG_LENGTHS:  lens_d      = pwdata[LENS_W-1:0];
        REG_COUNT:    count_d     = pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      lens_q   <= '0;
      count_q  <= '0;
    end else begin
      needle_q <= needle_d;
      lens_q   <= lens_d;
      count_q  <= count_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_NEEDLE_A: prdata = needle_q[0];
      REG_NEEDLE_B: prdata = needle_q[1];
      REG_NEEDLE_C: prdata = needle_q[2];
      REG_NEEDLE_D: prdata = needle_q[3];
      REG_LENGTHS:  prdata = {{(APB_DW-LENS_W){1'b0}}, lens_q};
      REG_COUNT:    prdata = {{(APB_DW-COUNT_W){1'b0}}, count_q};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.needle = needle_q;
    cfg_o.count  = count_q;
    for (int k = 0; k < REG_SLOTS; k++) begin
      cfg_o.len[k] = lens_q[k*LEN_W +: LEN_W];
    end
  end

endmodule

FILE: hw/rtl/mnm_cell.sv
module mnm_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  logic [mnm_pkg::POS_W-1:0]          pos_i,
  input  mnm_pkg::win_t                      win_i,
  input  mnm_pkg::cfg_t                      cfg_i,
  output mnm_pkg::win_t                      win_o,
  output logic [mnm_pkg::LIVE_SLOTS-1:0]     ok_o
);
  import mnm_pkg::*;

  win_t        win_q;
  logic [3:0]  pos_ext;
  logic [2:0]  sel;
  logic [7:0]  want;

  assign pos_ext = 4'(pos_i);
  assign win_o   = win_q;

  // ok when this position is outside the needle or matches its byte;
  // judged on the byte that enters this cell with the current beat
  always_comb begin
    for (int k = 0; k < LIVE_SLOTS; k++) begin
      sel  = 3'(cfg_i.len[k] - pos_ext - 4'd1);
      want = cfg_i.needle[k][{sel, 3'b000} +: 8];
      if (pos_ext >= cfg_i.len[k]) begin
        ok_o[k] = 1'b1;
      end else begin
        ok_o[k] = win_i.valid && (fold_case(win_i.data) == fold_case(want));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_i;
    end
  end

endmodule

FILE: hw/rtl/multi_needle_case_insensitive_match.sv
// case-insensitive multi-needle matcher for a byte stream
// slave stream: one byte per beat in s_axis_tdata, s_axis_tuser set clears
//   the byte window, the fill state and the sticky found flag before the byte
// master stream: one result beat for every input beat, in order
// config: apb registers at 8*i: needle a..d, packed lengths, needle count;
//   the user writes them only while the stream is idle, the block does not enforce it; pready always high
// the window is a chain of byte cells; on each accepted beat every cell takes
//   its neighbor's byte and checks it against the needle byte that belongs at
//   its position for every needle, so all needles and all starts are checked
//   in parallel and ascii letters compare without regard to case
// the result of each accepted input beat is registered in the output register
// throughput: one beat per cycle; the output register takes a new result in
//   the cycle the old one leaves, so a held tready gives no bubbles
// stall: while m_axis_tready is low and a result waits, s_axis_tready drops
// reset: window empty, found clear, config registers zero, no result pending
module multi_needle_case_insensitive_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mnm_pkg::APB_AW-1:0]   paddr,
  input  logic [mnm_pkg::APB_DW-1:0]   pwdata,
  output logic [mnm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // data_byte
  input  logic                         s_axis_tuser,   // restart
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata    // hit, hit_index[1:0], found, zero pad
);
  import mnm_pkg::*;

  cfg_t                                   cfg;
  win_t [MAX_NEEDLE_LEN-1:0]              win_in;
  win_t [MAX_NEEDLE_LEN-1:0]              win_q;
  logic [MAX_NEEDLE_LEN-1:0][LIVE_SLOTS-1:0] ok;
  logic [LIVE_SLOTS-1:0]                  slot_hit;
  logic                                   accept;
  logic                                   hit;
  logic [1:0]                             hit_index;
  logic                                   found_q, found_d;
  logic                                   out_valid_q, out_valid_d;
  logic                                   out_hit_q;
  logic [1:0]                             out_index_q;
  logic                                   out_found_q;

  mnm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // output register frees up when its beat is taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // window chain: newest byte enters cell 0; restart empties the older cells
  always_comb begin
    win_in[0].data  = s_axis_tdata;
    win_in[0].valid = 1'b1;
    for (int j = 1; j < MAX_NEEDLE_LEN; j++) begin
      win_in[j] = s_axis_tuser ? '0 : win_q[j-1];
    end
  end

  for (genvar j = 0; j < MAX_NEEDLE_LEN; j++) begin : g_cell
    mnm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .pos_i   (POS_W'(j)),
      .win_i   (win_in[j]),
      .cfg_i   (cfg),
      .win_o   (win_q[j]),
      .ok_o    (ok[j])
    );
  end

  // a needle hits when it is in use, has a usable length and every cell agrees
  always_comb begin
    for (int k = 0; k < LIVE_SLOTS; k++) begin
      slot_hit[k] = (COUNT_W'(k) < cfg.count) && (cfg.len[k] != '0)
                    && (cfg.len[k] <= LEN_W'(MAX_NEEDLE_LEN));
      for (int j = 0; j < MAX_NEEDLE_LEN; j++) begin
        slot_hit[k] = slot_hit[k] && ok[j][k];
      end
    end
  end

  // lowest index wins
  always_comb begin
    hit       = |slot_hit;
    hit_index = '0;
    for (int k = LIVE_SLOTS - 1; k >= 0; k--) begin
      if (slot_hit[k]) begin
        hit_index = 2'(k);
      end
    end
  end

  always_comb begin
    found_d = found_q;
    if (accept) begin
      found_d = (found_q && !s_axis_tuser) || hit;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_hit_q   <= hit;
      out_index_q <= hit_index;
      out_found_q <= found_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_found_q, out_index_q, out_hit_q};

`ifndef ASSERT_OFF
  // a reported hit is always reflected in the sticky flag
  a_hit_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3])
    else $error("hit without found");

  // the index is zero whenever there is no hit
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'b00)
    else $error("hit_index set without hit");

  // found only clears on a restart beat
  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !(accept && s_axis_tuser) |=> found_q)
    else $error("found dropped without restart");

  // input stalls only behind a waiting result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q && !m_axis_tready)
    else $error("input stalled without a pending result");
`endif

endmodule

FILE: bench/mnm_match_checker.sv
module mnm_match_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [mnm_pkg::APB_AW-1:0]   paddr,
  input  logic [mnm_pkg::APB_DW-1:0]   pwdata,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // data_byte
  input  logic                         s_axis_tuser,   // restart
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [7:0]                   m_axis_tdata,   // hit, hit_index[1:0], found, zero pad
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import mnm_pkg::*;

  typedef struct packed {
    logic       hit;
    logic [1:0] hit_index;
    logic       found;
  } match_beat_t;

  logic [NEEDLE_W-1:0] needle_q [REG_SLOTS];
  logic [LENS_W-1:0]   lens_q;
  logic [COUNT_W-1:0]  count_q;
  logic [7:0]          window_q [MAX_NEEDLE_LEN];
  int unsigned         fill_q;
  logic                found_q;
  int unsigned         mismatches_q;
  match_beat_t         due_q [$];

  // letters compare without regard to case, everything else literally
  function automatic logic same_letter(input logic [7:0] x, input logic [7:0] y);
    if (x == y) return 1'b1;
    if (x >= UPPER_A && x <= UPPER_Z && y == x + CASE_GAP) return 1'b1;
    if (x >= LOWER_A && x <= LOWER_Z && y == x - CASE_GAP) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic needle_ends_here(input int k);
    int unsigned len;
    len = lens_q[LEN_W*k +: LEN_W];
    if (len == 0 || len > MAX_NEEDLE_LEN || len > fill_q) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (!same_letter(window_q[len-1-i], needle_q[k][8*i +: 8])) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic restart, output match_beat_t r);
    int unsigned live;
    if (restart) begin
      for (int i = 0; i < MAX_NEEDLE_LEN; i++) window_q[i] = '0;
      fill_q  = 0;
      found_q = 1'b0;
    end
    for (int i = MAX_NEEDLE_LEN - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = b;
    if (fill_q < MAX_NEEDLE_LEN) fill_q++;
    live = count_q;
    if (live > LIVE_SLOTS) live = LIVE_SLOTS;
    r = '0;
    for (int k = 0; k < live; k++) begin
      if (!r.hit && needle_ends_here(k)) begin
        r.hit       = 1'b1;
        r.hit_index = 2'(k);
      end
    end
    if (r.hit) found_q = 1'b1;
    r.found = found_q;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches_q++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    match_beat_t want;
    match_beat_t got;
    if (!rst_ni) begin
      for (int k = 0; k < REG_SLOTS; k++) needle_q[k] = '0;
      for (int i = 0; i < MAX_NEEDLE_LEN; i++) window_q[i] = '0;
      lens_q       = '0;
      count_q      = '0;
      fill_q       = 0;
      found_q      = 1'b0;
      mismatches_q = 0;
      due_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:3])
          REG_NEEDLE_A, REG_NEEDLE_B, REG_NEEDLE_C, REG_NEEDLE_D: begin
            needle_q[paddr[APB_AW-2:3]] = pwdata[NEEDLE_W-1:0];
          end
          REG_LENGTHS: begin
            lens_q = pwdata[LENS_W-1:0];
          end
          REG_COUNT: begin
            count_q = pwdata[COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with none due", m_axis_tdata));
        end else begin
          want = due_q.pop_front();
          got  = {m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tdata[3]};
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
          if (got.hit_index !== want.hit_index)
            report_mismatch($sformatf("hit_index %0d, want %0d", got.hit_index,
                                      want.hit_index));
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
          if (m_axis_tdata[7:4] !== 4'b0)
            report_mismatch($sformatf("pad bits 0x%01h, want 0", m_axis_tdata[7:4]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_byte(s_axis_tdata, s_axis_tuser, want);
        due_q.push_back(want);
      end
      fail_count_o <= mismatches_q;
      pending_o    <= due_q.size();
    end
  end

endmodule

FILE: bench/tb_multi_needle_case_insensitive_match.sv
module tb_multi_needle_case_insensitive_match;
  import mnm_pkg::*;

  // register indexes past the last real one; writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  // cycles with no beat and no register access before the run is called hung
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_BEATS = 240;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // data_byte
  logic                s_axis_tuser;   // restart
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // hit, hit_index[1:0], found, zero pad

  int unsigned         mismatches;
  int unsigned         results_due;
  int unsigned         quiet_cycles = 0;

  // idling knobs, changed per phase; calm shuts all idling off for the tail
  bit                  calm = 1'b0;
  int unsigned         gap_pct = 0;
  int unsigned         stall_pct = 0;

  multi_needle_case_insensitive_match dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // watches both streams and the register port, predicts and compares
  mnm_match_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (mismatches),
    .pending_o     (results_due)
  );

  always #5 clk_i = ~clk_i;

  // hang detector: any accepted beat or register access restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side backpressure: random stall bursts
  initial begin
    int unsigned hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        hold          = $urandom_range(0, 8);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // needle text packed with the first character in the low byte
  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // letters around the case boundaries plus a few that only look foldable
  function automatic logic [7:0] pool_byte();
    string pool;
    pool = "aAbBzZ@[`{0p";
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if ((b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z)) return b ^ CASE_GAP;
    return b;
  endfunction

  // one register write: setup phase, then access phase until pready
  task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_needles(input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] c, input logic [63:0] d,
                              input logic [LENS_W-1:0] lens, input logic [COUNT_W-1:0] cnt);
    apb_write(REG_NEEDLE_A, a);
    apb_write(REG_NEEDLE_B, b);
    apb_write(REG_NEEDLE_C, c);
    apb_write(REG_NEEDLE_D, d);
    apb_write(REG_LENGTHS, 64'(lens));
    apb_write(REG_COUNT, 64'(cnt));
  endtask

  // one input beat; tvalid stays high into the next beat unless a gap follows
  task automatic send_beat(input logic [7:0] b, input logic restart);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = restart;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // registers change only with no result outstanding and the pipe settled
  task automatic drain_stream();
    s_axis_tvalid = 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // fresh needles, then a stream built mostly from needle copies in mixed case
  task automatic run_random_phase(input int unsigned beats, input int unsigned idle_pct);
    logic [63:0]        nd [REG_SLOTS];
    logic [LEN_W-1:0]   ln [REG_SLOTS];
    logic [LENS_W-1:0]  lens;
    logic [COUNT_W-1:0] cnt;
    int unsigned        sent;
    int unsigned        k;
    int unsigned        n;
    int unsigned        pick;
    logic [7:0]         b;
    lens = '0;
    for (int j = 0; j < REG_SLOTS; j++) begin
      for (int i = 0; i < 8; i++) nd[j][8*i +: 8] = pool_byte();
      pick = $urandom_range(0, 9);
      if (pick == 0) ln[j] = '0;
      else if (pick == 1) ln[j] = LEN_W'($urandom_range(MAX_NEEDLE_LEN + 1, 15));
      else if (pick < 5) ln[j] = LEN_W'($urandom_range(1, 3));
      else ln[j] = LEN_W'($urandom_range(1, MAX_NEEDLE_LEN));
      lens[LEN_W*j +: LEN_W] = ln[j];
    end
    cnt = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 7)) : COUNT_W'(REG_SLOTS);
    drain_stream();
    load_needles(nd[0], nd[1], nd[2], nd[3], lens, cnt);
    if ($urandom_range(0, 3) == 0) begin
      apb_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                {$urandom, $urandom});
    end
    gap_pct   = idle_pct;
    stall_pct = idle_pct;
    sent      = 0;
    while (sent < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // a needle copy, random case per letter, now and then one byte spoiled
        k = $urandom_range(0, REG_SLOTS - 1);
        n = (ln[k] > MAX_NEEDLE_LEN) ? MAX_NEEDLE_LEN : ln[k];
        for (int i = 0; i < n; i++) begin
          b = nd[k][8*i +: 8];
          if ($urandom_range(0, 1) == 1) b = flip_case(b);
          if ($urandom_range(0, 19) == 0) b = 8'($urandom);
          send_beat(b, $urandom_range(0, 29) == 0);
          sent++;
        end
      end else if (pick < 90) begin
        send_beat(pool_byte(), $urandom_range(0, 29) == 0);
        sent++;
      end else begin
        send_beat(8'($urandom), $urandom_range(0, 29) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // registers still at reset: no needle in use, nothing can hit
    send_beat("x", 1'b1);

    // mixed-case needle, overlapping pair, zero bytes inside a full-length
    // needle, and a one-byte non-letter needle that must not fold
    drain_stream();
    load_needles(pack_text("HeLlo"), pack_text("LL"), 64'h0171_80ff_005a_0061,
                 pack_text("@"), 16'h1825, 3'd4);
    // spare indexes must leave every real register alone
    apb_write(REG_SPARE_LO, '1);
    apb_write(REG_SPARE_HI, 64'h5555_aaaa_5555_aaaa);
    send_beat("h", 1'b1);
    send_text("ElLOlL`@");
    // short history after restart: the pair needs two bytes first
    send_beat("l", 1'b1);
    send_beat("L", 1'b0);
    send_beat("A", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat("z", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat("Q", 1'b0);
    send_beat(8'h01, 1'b0);

    // count above the slots saturates, overlong lengths disable, length 0
    // disables, all-ones needle of full length
    drain_stream();
    load_needles(pack_text("hello"), pack_text("LLLLLLLL"), '0, '1, 16'h80f9, 3'd7);
    send_beat(8'hff, 1'b1);
    for (int i = 0; i < MAX_NEEDLE_LEN; i++) send_beat(8'hff, 1'b0);
    // no needle in use while the window still matches
    drain_stream();
    apb_write(REG_COUNT, '0);
    send_beat(8'hff, 1'b0);

    // random phases with varied idling, some phases with none at all
    run_random_phase(PHASE_BEATS, 20);
    run_random_phase(PHASE_BEATS, 0);
    run_random_phase(PHASE_BEATS, 35);
    run_random_phase(PHASE_BEATS, 10);
    run_random_phase(PHASE_BEATS, 50);
    run_random_phase(PHASE_BEATS, 0);
    run_random_phase(PHASE_BEATS, 25);
    calm = 1'b1;
    run_random_phase(PHASE_BEATS, 0);

    // drain the last results and let the output register settle
    s_axis_tvalid = 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
